>>> rtl/wsg_pkg.sv
// Shared types, constants and tables of the wavetable sample generator.
`default_nettype none

package wsg_pkg;

   localparam int WSG_INDEX_W    = 12;
   localparam int WSG_LEN_W      = 13;
   localparam int WSG_KIND_W     = 2;
   localparam int WSG_SAMPLE_W   = 16;
   localparam int WSG_DIVIDEND_W = 44;
   localparam int WSG_DIVISOR_W  = 13;
   localparam int WSG_QUOT_W     = 31;
   localparam int WSG_TERMS      = 8;
   localparam int WSG_SERIES_STAGES = 1 + 3 * WSG_TERMS;

   localparam int WSG_QUEUE_DEPTH = 4;
   localparam int WSG_PTR_W       = $clog2(WSG_QUEUE_DEPTH);
   localparam int WSG_COUNT_W     = $clog2(WSG_QUEUE_DEPTH + 1);

   localparam logic [WSG_LEN_W-1:0] WSG_MAX_LEN   = 13'd4096;
   localparam logic [WSG_LEN_W-1:0] WSG_MIN_LEN   = 13'd2;
   localparam logic [WSG_LEN_W-1:0] WSG_LEN_RESET = 13'd1024;

   // (pi/2) in Q30.
   localparam logic [30:0] WSG_HALF_PI_Q30 = 31'd1686629713;

   // Wave kinds.
   localparam logic [WSG_KIND_W-1:0] WAVE_SINE     = 2'd0;
   localparam logic [WSG_KIND_W-1:0] WAVE_SQUARE   = 2'd1;
   localparam logic [WSG_KIND_W-1:0] WAVE_TRIANGLE = 2'd2;
   localparam logic [WSG_KIND_W-1:0] WAVE_SAW      = 2'd3;

   // Register indexes.
   typedef logic [0:0] wsg_csr_index_type;
   localparam wsg_csr_index_type CSR_WAVE_KIND    = 1'b0;
   localparam wsg_csr_index_type CSR_TABLE_LENGTH = 1'b1;

   // Series divisors (2j)(2j+1) and their reciprocals floor(2^34 / divisor).
   localparam logic [8:0] WSG_DIVS [1:WSG_TERMS] = '{
      9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272};
   localparam logic [31:0] WSG_RECIP [1:WSG_TERMS] = '{
      32'(64'd17179869184 / 64'd6),   32'(64'd17179869184 / 64'd20),
      32'(64'd17179869184 / 64'd42),  32'(64'd17179869184 / 64'd72),
      32'(64'd17179869184 / 64'd110), 32'(64'd17179869184 / 64'd156),
      32'(64'd17179869184 / 64'd210), 32'(64'd17179869184 / 64'd272)};

   typedef struct packed {
      logic                    oor;
      logic                    is_sine;
      logic                    is_ramp;
      logic                    negate;
      logic [WSG_SAMPLE_W-1:0] fixed_value;
   } wsg_tag_type;

   typedef struct packed {
      wsg_tag_type               tag;
      logic [WSG_DIVIDEND_W-1:0] dividend;
      logic [WSG_DIVISOR_W-1:0]  divisor;
   } wsg_job_type;

endpackage

`default_nettype wire

>>> rtl/wsg_front.sv
// Front end: range check, shape classification and the job queue.
`default_nettype none

module wsg_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   input  wire logic [wsg_pkg::WSG_INDEX_W-1:0] req_entry_index,
   output logic                               req_full,
   input  wire logic [wsg_pkg::WSG_KIND_W-1:0] wave_kind,
   input  wire logic [wsg_pkg::WSG_LEN_W-1:0] table_length,
   output logic                               job_valid,
   output wsg_pkg::wsg_job_type               job,
   input  wire logic                          job_pop
);
   import wsg_pkg::*;

   logic [WSG_LEN_W-1:0]   n;
   logic [WSG_INDEX_W-1:0] d;
   logic                   oor;
   logic                   first;
   logic [13:0]            q4;
   logic [13:0]            n2;
   logic                   k1;
   logic                   k0;
   logic [13:0]            rem1;
   logic [WSG_LEN_W-1:0]   r;
   logic [WSG_LEN_W-1:0]   m;
   logic signed [15:0]     i4;
   logic signed [15:0]     i2;
   logic signed [15:0]     ds;
   logic signed [15:0]     d3;
   logic signed [15:0]     t_a;
   logic signed [15:0]     t_b;
   logic signed [15:0]     abs_a;
   logic signed [15:0]     abs_b;
   logic signed [15:0]     num;
   logic [14:0]            mag;
   wsg_job_type            new_job;

   wsg_job_type                q_ff [WSG_QUEUE_DEPTH];
   logic [WSG_PTR_W-1:0]       wr_ptr_ff;
   logic [WSG_PTR_W-1:0]       wr_ptr_in;
   logic [WSG_PTR_W-1:0]       rd_ptr_ff;
   logic [WSG_PTR_W-1:0]       rd_ptr_in;
   logic [WSG_COUNT_W-1:0]     count_ff;
   logic [WSG_COUNT_W-1:0]     count_in;
   logic                       do_push;
   logic                       do_pop;

   always_comb begin
      if (table_length < WSG_MIN_LEN) begin
         n = WSG_MIN_LEN;
      end else if (table_length > WSG_MAX_LEN) begin
         n = WSG_MAX_LEN;
      end else begin
         n = table_length;
      end
      d     = WSG_INDEX_W'(n - 13'd1);
      oor   = {1'b0, req_entry_index} >= n;
      first = {1'b0, req_entry_index} < (n >> 1);

      // Quadrant and position within it for the sine.
      q4   = {req_entry_index, 2'b00};
      n2   = {n, 1'b0};
      k1   = q4 >= n2;
      rem1 = k1 ? q4 - n2 : q4;
      k0   = rem1 >= {1'b0, n};
      r    = k0 ? WSG_LEN_W'(rem1 - {1'b0, n}) : WSG_LEN_W'(rem1);
      m    = k0 ? n - r : r;

      // Ramp numerators over the denominator N-1.
      i4    = $signed({2'b00, req_entry_index, 2'b00});
      i2    = $signed({3'b000, req_entry_index, 1'b0});
      ds    = $signed({4'b0000, d});
      d3    = ds + (ds <<< 1);
      t_a   = i4 - ds;
      t_b   = i4 - d3;
      abs_a = t_a[15] ? -t_a : t_a;
      abs_b = t_b[15] ? -t_b : t_b;
      if (wave_kind == WAVE_TRIANGLE) begin
         num = first ? ds - abs_a : abs_b - ds;
      end else begin
         num = first ? i2 : i2 - (ds <<< 1);
      end
      mag = num[15] ? 15'(-num) : 15'(num);

      new_job                   = '0;
      new_job.divisor           = n;
      new_job.tag.fixed_value   = '0;
      case (wave_kind)
         WAVE_SINE: begin
            new_job.tag.is_sine = 1'b1;
            new_job.tag.negate  = k1;
            new_job.dividend    = 44'(m) * 44'(WSG_HALF_PI_Q30);
         end
         WAVE_SQUARE: begin
            new_job.tag.fixed_value = first ? 16'h7FFF : 16'h8000;
         end
         WAVE_TRIANGLE, WAVE_SAW: begin
            new_job.tag.is_ramp = 1'b1;
            new_job.tag.negate  = num[15];
            new_job.dividend    = 44'({mag, 16'h0000}) + 44'(d);
            new_job.divisor     = {d, 1'b0};
         end
         default: begin
            new_job.tag.fixed_value = '0;
         end
      endcase
      if (oor) begin
         new_job.tag = '{oor: 1'b1, is_sine: 1'b0, is_ramp: 1'b0, negate: 1'b0,
                         fixed_value: '0};
      end
   end

   assign req_full  = count_ff == WSG_COUNT_W'(WSG_QUEUE_DEPTH);
   assign job_valid = count_ff != '0;
   assign job       = q_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = job_pop && job_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + WSG_COUNT_W'(do_push) - WSG_COUNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

`default_nettype wire

>>> rtl/wsg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module wsg_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic                         in_valid,
   input  wire wsg_pkg::wsg_job_type         in_job,
   output logic                              out_valid,
   output logic [wsg_pkg::WSG_QUOT_W-1:0]    out_quot,
   output wsg_pkg::wsg_tag_type              out_tag
);
   import wsg_pkg::*;

   logic                      valid_ff [WSG_QUOT_W];
   logic [WSG_DIVIDEND_W-1:0] rem_ff   [WSG_QUOT_W];
   logic [WSG_DIVIDEND_W-1:0] rem_in   [WSG_QUOT_W];
   logic [WSG_QUOT_W-1:0]     quot_ff  [WSG_QUOT_W];
   logic [WSG_QUOT_W-1:0]     quot_in  [WSG_QUOT_W];
   logic [WSG_DIVISOR_W-1:0]  dvs_ff   [WSG_QUOT_W];
   wsg_tag_type               tag_ff   [WSG_QUOT_W];

   for (genvar s = 0; s < WSG_QUOT_W; s++) begin : g_stage
      localparam int B = WSG_QUOT_W - 1 - s;
      logic                      src_valid;
      logic [WSG_DIVIDEND_W-1:0] src_rem;
      logic [WSG_QUOT_W-1:0]     src_quot;
      logic [WSG_DIVISOR_W-1:0]  src_dvs;
      wsg_tag_type               src_tag;
      logic [WSG_DIVIDEND_W-1:0] shifted;

      if (s == 0) begin : g_head
         assign src_valid = in_valid;
         assign src_rem   = in_job.dividend;
         assign src_quot  = '0;
         assign src_dvs   = in_job.divisor;
         assign src_tag   = in_job.tag;
      end else begin : g_body
         assign src_valid = valid_ff[s-1];
         assign src_rem   = rem_ff[s-1];
         assign src_quot  = quot_ff[s-1];
         assign src_dvs   = dvs_ff[s-1];
         assign src_tag   = tag_ff[s-1];
      end

      assign shifted = WSG_DIVIDEND_W'(src_dvs) << B;

      always_comb begin
         quot_in[s] = src_quot;
         rem_in[s]  = src_rem;
         if (src_rem >= shifted) begin
            rem_in[s]     = src_rem - shifted;
            quot_in[s][B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s]  <= rem_in[s];
            quot_ff[s] <= quot_in[s];
            dvs_ff[s]  <= src_dvs;
            tag_ff[s]  <= src_tag;
         end
      end
   end

   assign out_valid = valid_ff[WSG_QUOT_W-1];
   assign out_quot  = quot_ff[WSG_QUOT_W-1];
   assign out_tag   = tag_ff[WSG_QUOT_W-1];

endmodule

`default_nettype wire

>>> rtl/wsg_finish.sv
// Back end: sine series, rounding, saturation and the result queue.
`default_nettype none

module wsg_finish (
   input  wire logic                          clock,
   input  wire logic                          reset,
   output logic                               advance,
   input  wire logic                          in_valid,
   input  wire logic [wsg_pkg::WSG_QUOT_W-1:0] in_quot,
   input  wire wsg_pkg::wsg_tag_type          in_tag,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic signed [wsg_pkg::WSG_SAMPLE_W-1:0] rsp_sample_value,
   output logic                               rsp_index_out_of_range
);
   import wsg_pkg::*;

   typedef struct packed {
      wsg_tag_type         tag;
      logic [30:0]         x;
      logic [31:0]         x2;
      logic signed [33:0]  sum;
      logic [32:0]         p;
      logic [32:0]         q0;
   } wsg_series_type;

   logic           valid_ff [WSG_SERIES_STAGES];
   wsg_series_type st_ff    [WSG_SERIES_STAGES];
   wsg_series_type st_in    [WSG_SERIES_STAGES];

   always_comb begin
      st_in[0]     = '0;
      st_in[0].tag = in_tag;
      st_in[0].x   = in_quot;
      st_in[0].x2  = 32'((64'(in_quot) * 64'(in_quot)) >> 30);
      st_in[0].sum = $signed(34'(in_quot));
      st_in[0].q0  = 33'(in_quot);
   end

   // Each series term takes three stages: multiply by x^2, multiply by the
   // reciprocal of its divisor, then correct the quotient and accumulate.
   for (genvar j = 1; j <= WSG_TERMS; j++) begin : g_term
      localparam int P = 3 * j - 2;
      localparam int R = 3 * j - 1;
      localparam int C = 3 * j;
      localparam bit SUBTRACT = (j % 2) == 1;
      logic [32:0] rem;
      logic [32:0] term;

      always_comb begin
         st_in[P]   = st_ff[P-1];
         st_in[P].p = 33'((65'(st_ff[P-1].q0) * 65'(st_ff[P-1].x2)) >> 30);

         st_in[R]    = st_ff[P];
         st_in[R].q0 = 33'((66'(st_ff[P].p) * 66'(WSG_RECIP[j])) >> 34);

         rem  = st_ff[R].p - st_ff[R].q0 * 33'(WSG_DIVS[j]);
         term = (rem >= 33'(WSG_DIVS[j])) ? st_ff[R].q0 + 33'd1 : st_ff[R].q0;
         st_in[C]    = st_ff[R];
         st_in[C].q0 = term;
         if (SUBTRACT) begin
            st_in[C].sum = st_ff[R].sum - $signed({1'b0, term});
         end else begin
            st_in[C].sum = st_ff[R].sum + $signed({1'b0, term});
         end
      end
   end

   for (genvar s = 0; s < WSG_SERIES_STAGES; s++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= (s == 0) ? in_valid : valid_ff[(s == 0) ? 0 : s - 1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   // Final value.
   wsg_series_type          last;
   logic [33:0]             s_pos;
   logic [33:0]             s_round;
   logic [30:0]             mag;
   logic [WSG_SAMPLE_W-1:0] value;

   always_comb begin
      last    = st_ff[WSG_SERIES_STAGES-1];
      s_pos   = last.sum[33] ? '0 : 34'(last.sum);
      s_round = (s_pos + 34'd16384) >> 15;
      mag     = last.tag.is_sine ? 31'(s_round) : last.x;
      if (last.tag.oor) begin
         value = '0;
      end else if (last.tag.is_sine || last.tag.is_ramp) begin
         if (last.tag.negate) begin
            value = (mag >= 31'd32768) ? 16'h8000 : 16'(~mag[15:0] + 16'd1);
         end else begin
            value = (mag > 31'd32767) ? 16'h7FFF : mag[15:0];
         end
      end else begin
         value = last.tag.fixed_value;
      end
   end

   // Result queue.
   logic [WSG_SAMPLE_W-1:0] val_q_ff  [WSG_QUEUE_DEPTH];
   logic                    flag_q_ff [WSG_QUEUE_DEPTH];
   logic [WSG_PTR_W-1:0]    wr_ptr_ff;
   logic [WSG_PTR_W-1:0]    wr_ptr_in;
   logic [WSG_PTR_W-1:0]    rd_ptr_ff;
   logic [WSG_PTR_W-1:0]    rd_ptr_in;
   logic [WSG_COUNT_W-1:0]  count_ff;
   logic [WSG_COUNT_W-1:0]  count_in;
   logic                    do_push;
   logic                    do_pop;

   assign advance   = count_ff != WSG_COUNT_W'(WSG_QUEUE_DEPTH);
   assign rsp_empty = count_ff == '0;
   assign do_push   = advance && valid_ff[WSG_SERIES_STAGES-1];
   assign do_pop    = rsp_pop && !rsp_empty;
   assign rsp_sample_value       = $signed(val_q_ff[rd_ptr_ff]);
   assign rsp_index_out_of_range = flag_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + WSG_COUNT_W'(do_push) - WSG_COUNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         val_q_ff[wr_ptr_ff]  <= value;
         flag_q_ff[wr_ptr_ff] <= last.tag.oor;
      end
   end

endmodule

`default_nettype wire

>>> rtl/wavetable_sample_generator.sv
// Top level of the wavetable sample generator.
//
//   Channel   Direction  Handshake            Beat
//   req_      in         req_push / req_full  req_entry_index
//   rsp_      out        rsp_pop / rsp_empty  rsp_sample_value, rsp_index_out_of_range
//   csr_      in         csr_we               csr_index, csr_wdata
//
// One beat is accepted per clock cycle while req_full is low. A result passes
// through the job queue, the 31 stages of the divider (one quotient bit each)
// and the 25 stages of the sine series (one for x squared and three for each of
// the eight terms), the last of which writes the result queue.
// Synchronous reset empties both queues and the pipeline and restores the
// registers to sine and a length of 1024. When the result queue fills, the
// divider and the sine series hold; the four-entry job queue then absorbs
// further beats before req_full rises.
`default_nettype none

module wavetable_sample_generator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   output logic                                    req_full,
   input  wire logic [wsg_pkg::WSG_INDEX_W-1:0]    req_entry_index,
   output logic                                    rsp_empty,
   input  wire logic                               rsp_pop,
   output logic signed [wsg_pkg::WSG_SAMPLE_W-1:0] rsp_sample_value,
   output logic                                    rsp_index_out_of_range,
   input  wire logic                               csr_we,
   input  wire wsg_pkg::wsg_csr_index_type         csr_index,
   input  wire logic [wsg_pkg::WSG_LEN_W-1:0]      csr_wdata
);
   import wsg_pkg::*;

   // Configuration registers.
   logic [WSG_KIND_W-1:0] wave_kind_ff;
   logic [WSG_LEN_W-1:0]  table_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_kind_ff    <= WAVE_SINE;
         table_length_ff <= WSG_LEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WAVE_KIND:    wave_kind_ff    <= csr_wdata[WSG_KIND_W-1:0];
            CSR_TABLE_LENGTH: table_length_ff <= csr_wdata;
            default:          wave_kind_ff    <= wave_kind_ff;
         endcase
      end
   end

   // The front end turns every beat into a division job: the sine takes its
   // angle in Q30, the ramps take their exact ratio scaled to Q15.
   logic                 job_valid;
   wsg_job_type          job;
   logic                 advance;
   logic                 div_valid;
   logic [WSG_QUOT_W-1:0] div_quot;
   wsg_tag_type          div_tag;

   wsg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_entry_index (req_entry_index),
      .req_full        (req_full),
      .wave_kind       (wave_kind_ff),
      .table_length    (table_length_ff),
      .job_valid       (job_valid),
      .job             (job),
      .job_pop         (advance)
   );

   wsg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (job_valid),
      .in_job    (job),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_tag   (div_tag)
   );

   // The back end evaluates the sine series on every job; the ramps and the
   // fixed values simply ride along and pick their result at the end.
   wsg_finish u_finish (
      .clock                  (clock),
      .reset                  (reset),
      .advance                (advance),
      .in_valid               (div_valid),
      .in_quot                (div_quot),
      .in_tag                 (div_tag),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_sample_value       (rsp_sample_value),
      .rsp_index_out_of_range (rsp_index_out_of_range)
   );

   // An out-of-range beat always carries a zero sample.
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_index_out_of_range |-> rsp_sample_value == 16'sd0)
      else $error("out-of-range result with nonzero sample");

   // Reset leaves no result waiting.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result waiting after reset");

   // A waiting result does not vanish unless it is popped.
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("waiting result lost");

endmodule

`default_nettype wire
